// File: hdl/srrf_pkg.sv
// Shared widths, constants and latencies for the soil respiration rate factor block.
package srrf_pkg;

   localparam int TEMP_W  = 15;
   localparam int WATER_W = 24;
   localparam int KM_W    = 16;
   localparam int APP_W   = 16;
   localparam int RATE_W  = 24;

   localparam int FT_W = 36;  // temperature factor, Q30
   localparam int FS_W = 25;  // limiting factor, Q24

   localparam logic signed [TEMP_W-1:0] TEMP_COLD = -15'sd5120;

   localparam logic [63:0] TOFF_Q16  = 64'd3015967;
   localparam logic [63:0] DREF_Q16  = 64'd3671327;
   localparam logic [63:0] BCOEF_Q40 = 64'd339265307866563;

   localparam int RCP_NW = 49;
   localparam int RCP_DW = 23;
   localparam int RCP_QW = 28;

   localparam logic [63:0] RREF_WIDE = (BCOEF_Q40 + (DREF_Q16 >> 1)) / DREF_Q16;
   localparam logic [RCP_QW-1:0] RREF = RREF_WIDE[RCP_QW-1:0];
   localparam logic [63:0] NUM0_WIDE = BCOEF_Q40 + (TOFF_Q16 >> 1);
   localparam logic [RCP_NW-1:0] NUM0 = NUM0_WIDE[RCP_NW-1:0];

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [30:0] ONE_Q30   = 31'd1073741824;
   localparam logic [FT_W-1:0] FLOOR_Q30 = 36'd10737418;
   localparam int TERMS = 12;

   localparam int DIV_QW = 32;
   localparam int MST_NW = 60;
   localparam int MST_DW = 41;
   localparam int APP_NW = 48;
   localparam int APP_DW = 17;

   localparam logic [FS_W-1:0] ONE_Q24   = 25'd16777216;
   localparam logic [26:0]     THREE_Q24 = 27'd50331648;
   localparam logic [63:0] DIV5_WIDE = ((64'd1 << 30) + 64'd4) / 64'd5;
   localparam logic [27:0] DIV5_MUL  = DIV5_WIDE[27:0];

   localparam logic [62:0] ROUND_HALF = 63'd137438953472;
   localparam logic [RATE_W:0] OUT_MAX = 25'h0FFFFFF;

   localparam int TEMP_LAT    = 1 + RCP_QW + 3 + 2 * TERMS + 2;
   localparam int RATIO_LAT   = 2 + DIV_QW + 3;
   localparam int RATIO_DELAY = TEMP_LAT - RATIO_LAT;
   localparam int PIPE_LAT    = TEMP_LAT + 3;

endpackage

// File: hdl/srrf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module srrf_div #(
   parameter int NW = 49,
   parameter int DW = 23,
   parameter int QW = 28,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag_i,
   output logic [QW-1:0] quo,
   output logic [TW-1:0] tag_o
);

   logic [DW-1:0] rem_src  [QW];
   logic [QW-1:0] bits_src [QW];
   logic [DW-1:0] den_src  [QW];
   logic [TW-1:0] tag_src  [QW];

   logic [DW-1:0] rem_ff  [QW-1];
   logic [DW-1:0] den_ff  [QW-1];
   logic [QW-1:0] bits_ff [QW];
   logic [TW-1:0] tag_ff  [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] bits_in;

      if (i == 0) begin : g_first
         assign rem_src[i]  = DW'(num[NW-1:QW]);
         assign bits_src[i] = num[QW-1:0];
         assign den_src[i]  = den;
         assign tag_src[i]  = tag_i;
      end else begin : g_next
         assign rem_src[i]  = rem_ff[i-1];
         assign bits_src[i] = bits_ff[i-1];
         assign den_src[i]  = den_ff[i-1];
         assign tag_src[i]  = tag_ff[i-1];
      end

      always_comb begin
         trial   = {rem_src[i], bits_src[i][QW-1]};
         diff    = trial - {1'b0, den_src[i]};
         ge      = (trial >= {1'b0, den_src[i]});
         rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         bits_in = {bits_src[i][QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            bits_ff[i] <= bits_in;
            tag_ff[i]  <= tag_src[i];
         end
      end

      if (i < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= rem_in;
               den_ff[i] <= den_src[i];
            end
         end
      end
   end

   assign quo   = bits_ff[QW-1];
   assign tag_o = tag_ff[QW-1];

endmodule

// File: hdl/srrf_temp.sv
// Lloyd-Taylor temperature factor: reciprocal divider, exponent scaling and 2^f series.
module srrf_temp (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [srrf_pkg::TEMP_W-1:0]  soil_temp,
   output logic [srrf_pkg::FT_W-1:0]           ft
);

   typedef struct packed {
      logic [29:0] t;
      logic [4:0]  ip;
      logic        warm;
   } side_type;

   logic [srrf_pkg::RCP_DW-1:0] d_in, d_ff;
   logic [srrf_pkg::RCP_NW-1:0] num_in, num_ff;
   logic                        warm_in, warm_ff;

   logic [srrf_pkg::RCP_QW-1:0] rcp;
   logic                        rcp_warm;

   logic signed [28:0] x_in, x_ff;
   logic               xw_ff;
   logic signed [58:0] x_ext;
   logic signed [58:0] p_in, p_ff;
   logic               pw_ff;
   logic [28:0]        u;
   logic [53:0]        tprod;
   side_type           t_side_in, t_side_ff;

   logic [59:0] a_pa_ff   [1:srrf_pkg::TERMS];
   logic [31:0] a_sum_ff  [1:srrf_pkg::TERMS];
   side_type    a_side_ff [1:srrf_pkg::TERMS];
   logic [30:0] b_term_ff [1:srrf_pkg::TERMS];
   logic [31:0] b_sum_ff  [1:srrf_pkg::TERMS];
   side_type    b_side_ff [1:srrf_pkg::TERMS];

   logic [31:0]               sumf_in, sumf_ff;
   logic [4:0]                fip_ff;
   logic                      fwarm_ff;
   logic [srrf_pkg::FT_W-1:0] shifted, ft_in, ft_ff;

   always_comb begin
      d_in    = {soil_temp, 8'b0} + srrf_pkg::TOFF_Q16[srrf_pkg::RCP_DW-1:0];
      num_in  = srrf_pkg::NUM0
              + {{(srrf_pkg::RCP_NW - srrf_pkg::TEMP_W - 7){soil_temp[srrf_pkg::TEMP_W-1]}},
                 soil_temp, 7'b0};
      warm_in = (soil_temp > srrf_pkg::TEMP_COLD);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         num_ff  <= num_in;
         warm_ff <= warm_in;
      end
   end

   srrf_div #(
      .NW (srrf_pkg::RCP_NW),
      .DW (srrf_pkg::RCP_DW),
      .QW (srrf_pkg::RCP_QW),
      .TW (1)
   ) u_rcp (
      .clock (clock),
      .en    (en),
      .num   (num_ff),
      .den   (d_ff),
      .tag_i (warm_ff),
      .quo   (rcp),
      .tag_o (rcp_warm)
   );

   always_comb begin
      x_in  = $signed({1'b0, srrf_pkg::RREF}) - $signed({1'b0, rcp});
      x_ext = $signed({{30{x_ff[28]}}, x_ff});
      p_in  = x_ext * $signed(59'(srrf_pkg::LOG2E_Q30));
      // offset by 2^58 flips the sign bit of a value known to lie in +-2^58
      u     = {~p_ff[58], p_ff[57:30]};
      tprod = 54'(u[23:0]) * 54'(srrf_pkg::LN2_Q30);
      t_side_in.t    = tprod[53:24];
      t_side_in.ip   = u[28:24];
      t_side_in.warm = pw_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff      <= x_in;
         xw_ff     <= rcp_warm;
         p_ff      <= p_in;
         pw_ff     <= xw_ff;
         t_side_ff <= t_side_in;
      end
   end

   for (genvar n = 1; n <= srrf_pkg::TERMS; n++) begin : g_term
      localparam int L = $clog2(n);
      localparam logic [63:0] MW = ((64'd1 << (30 + L)) + 64'(n) - 64'd1) / 64'(n);
      localparam logic [31:0] M  = MW[31:0];

      logic [30:0] term_src;
      logic [31:0] sum_src;
      side_type    side_src;
      logic [59:0] pa_in;
      logic [31:0] sum_in;
      logic [61:0] pb;
      logic [30:0] term_in;

      if (n == 1) begin : g_first
         assign term_src = srrf_pkg::ONE_Q30;
         assign sum_src  = '0;
         assign side_src = t_side_ff;
      end else begin : g_next
         assign term_src = b_term_ff[n-1];
         assign sum_src  = b_sum_ff[n-1];
         assign side_src = b_side_ff[n-1];
      end

      always_comb begin
         pa_in   = 60'(term_src) * 60'(side_src.t);
         sum_in  = sum_src + 32'(term_src);
         pb      = 62'(a_pa_ff[n][59:30]) * 62'(M);
         term_in = 31'(pb >> (30 + L));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_pa_ff[n]   <= pa_in;
            a_sum_ff[n]  <= sum_in;
            a_side_ff[n] <= side_src;
            b_term_ff[n] <= term_in;
            b_sum_ff[n]  <= a_sum_ff[n];
            b_side_ff[n] <= a_side_ff[n];
         end
      end
   end

   always_comb begin
      sumf_in = b_sum_ff[srrf_pkg::TERMS] + 32'(b_term_ff[srrf_pkg::TERMS]);
      if (fip_ff >= 5'd16) begin
         shifted = srrf_pkg::FT_W'(sumf_ff) << 4'(fip_ff - 5'd16);
      end else begin
         shifted = srrf_pkg::FT_W'(sumf_ff) >> 5'(5'd16 - fip_ff);
      end
      ft_in = fwarm_ff ? (shifted + srrf_pkg::FLOOR_Q30) : srrf_pkg::FLOOR_Q30;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sumf_ff  <= sumf_in;
         fip_ff   <= b_side_ff[srrf_pkg::TERMS].ip;
         fwarm_ff <= b_side_ff[srrf_pkg::TERMS].warm;
         ft_ff    <= ft_in;
      end
   end

   assign ft = ft_ff;

endmodule

// File: hdl/srrf_ratio.sv
// Moisture and appearance responses, their minimum, and alignment delay.
module srrf_ratio #(
   parameter int DELAY = srrf_pkg::RATIO_DELAY
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [srrf_pkg::WATER_W-1:0] soil_water,
   input  logic [srrf_pkg::WATER_W-1:0] field_capacity,
   input  logic [srrf_pkg::KM_W-1:0]    moisture_half_sat,
   input  logic [srrf_pkg::APP_W-1:0]   appearance,
   input  logic [srrf_pkg::APP_W-1:0]   appearance_half_sat,
   output logic [srrf_pkg::FS_W-1:0]    fs
);

   logic [39:0] kmfc_in, kmfc_ff;
   logic [23:0] w1_ff, w2_ff;
   logic [31:0] ak_in, ak1_ff, ak2_ff;
   logic [16:0] apk_in, apk1_ff, apk2_ff;
   logic        az_in, az1_ff, az2_ff;
   logic [srrf_pkg::MST_DW-1:0] den_in, den_ff;
   logic        mz_in, mz_ff;

   logic [srrf_pkg::DIV_QW-1:0] qm, qa;
   logic        mz_q, az_q;

   logic [srrf_pkg::FS_W-1:0] r, h;
   logic [26:0] vw_in, vw_ff, va_in, va_ff;
   logic [54:0] mw_in, mw_ff, ma_in, ma_ff;
   logic [srrf_pkg::FS_W-1:0] fw, fa, fs_in, fs_ff;

   always_comb begin
      kmfc_in = 40'(moisture_half_sat) * 40'(field_capacity);
      ak_in   = 32'(appearance) * 32'(appearance_half_sat);
      apk_in  = 17'(appearance) + 17'(appearance_half_sat);
      az_in   = (appearance == '0) && (appearance_half_sat == '0);
      den_in  = 41'(kmfc_ff) + 41'({w1_ff, 12'b0});
      mz_in   = (kmfc_ff == '0) && (w1_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kmfc_ff <= kmfc_in;
         w1_ff   <= soil_water;
         ak1_ff  <= ak_in;
         apk1_ff <= apk_in;
         az1_ff  <= az_in;
         den_ff  <= den_in;
         mz_ff   <= mz_in;
         w2_ff   <= w1_ff;
         ak2_ff  <= ak1_ff;
         apk2_ff <= apk1_ff;
         az2_ff  <= az1_ff;
      end
   end

   srrf_div #(
      .NW (srrf_pkg::MST_NW),
      .DW (srrf_pkg::MST_DW),
      .QW (srrf_pkg::DIV_QW),
      .TW (1)
   ) u_mst_div (
      .clock (clock),
      .en    (en),
      .num   ({w2_ff, 36'b0}),
      .den   (den_ff),
      .tag_i (mz_ff),
      .quo   (qm),
      .tag_o (mz_q)
   );

   srrf_div #(
      .NW (srrf_pkg::APP_NW),
      .DW (srrf_pkg::APP_DW),
      .QW (srrf_pkg::DIV_QW),
      .TW (1)
   ) u_app_div (
      .clock (clock),
      .en    (en),
      .num   ({ak2_ff, 16'b0}),
      .den   (apk2_ff),
      .tag_i (az2_ff),
      .quo   (qa),
      .tag_o (az_q)
   );

   // appearance term above one never wins the minimum, so it is clipped at one
   always_comb begin
      r = mz_q ? '0 : qm[srrf_pkg::FS_W-1:0];
      if (az_q) begin
         h = '0;
      end else if (qa > 32'(srrf_pkg::ONE_Q24)) begin
         h = srrf_pkg::ONE_Q24;
      end else begin
         h = qa[srrf_pkg::FS_W-1:0];
      end
      vw_in = {r, 2'b0} + 27'(srrf_pkg::ONE_Q24);
      va_in = 27'({h, 1'b0}) + srrf_pkg::THREE_Q24;
      mw_in = 55'(vw_ff) * 55'(srrf_pkg::DIV5_MUL);
      ma_in = 55'(va_ff) * 55'(srrf_pkg::DIV5_MUL);
      fw    = mw_ff[54:30];
      fa    = ma_ff[54:30];
      fs_in = (fw > fa) ? fa : fw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vw_ff <= vw_in;
         va_ff <= va_in;
         mw_ff <= mw_in;
         ma_ff <= ma_in;
         fs_ff <= fs_in;
      end
   end

   if (DELAY == 0) begin : g_nodly
      assign fs = fs_ff;
   end else begin : g_dly
      logic [srrf_pkg::FS_W-1:0] dly_ff [DELAY];
      for (genvar i = 0; i < DELAY; i++) begin : g_tap
         always_ff @(posedge clock) begin
            if (en) begin
               dly_ff[i] <= (i == 0) ? fs_ff : dly_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
      assign fs = dly_ff[DELAY-1];
   end

endmodule

// File: hdl/soil_respiration_rate_factor_top.sv
// Top level: soil respiration rate factor pipeline with output skid stage.
// One soil layer is accepted every clock cycle and each produces one result; the depth
// of the pipeline behind each transfer is set by the 28-stage reciprocal divider and the
// twelve two-stage terms of the 2^f series in the temperature path. A result waiting
// at the output does not stop intake; only a second waiting result (held in the skid
// register) stalls the whole pipeline. Result is
// ft * min(fw, fa) in unsigned Q8.16, rounded half up, with a clip flag.
module soil_respiration_rate_factor_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [srrf_pkg::TEMP_W-1:0]  req_soil_temp,
   input  logic [srrf_pkg::WATER_W-1:0]        req_soil_water,
   input  logic [srrf_pkg::WATER_W-1:0]        req_field_capacity,
   input  logic [srrf_pkg::KM_W-1:0]           req_moisture_half_sat,
   input  logic [srrf_pkg::APP_W-1:0]          req_appearance,
   input  logic [srrf_pkg::APP_W-1:0]          req_appearance_half_sat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [srrf_pkg::RATE_W-1:0]         rsp_rate_factor,
   output logic                                rsp_saturated
);

   localparam int LAT = srrf_pkg::PIPE_LAT;

   logic en;
   logic [LAT-1:0] vld_in, vld_ff;

   logic [srrf_pkg::FT_W-1:0] ft;
   logic [srrf_pkg::FS_W-1:0] fs;

   logic [42:0] ph_in, ph_ff, pl_in, pl_ff;
   logic [60:0] prod_in, prod_ff;
   logic [62:0] rnd;
   logic [srrf_pkg::RATE_W:0]   rate_full;
   logic [srrf_pkg::RATE_W-1:0] rate_in, rate_ff;
   logic                        sat_in, sat_ff;

   logic tail_vld;
   logic out_vld_in, out_vld_ff, skid_vld_in, skid_vld_ff;
   logic out_load, skid_load, out_from_skid;
   logic [srrf_pkg::RATE_W-1:0] out_rate_ff, skid_rate_ff;
   logic                        out_sat_ff, skid_sat_ff;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   srrf_temp u_temp (
      .clock     (clock),
      .en        (en),
      .soil_temp (req_soil_temp),
      .ft        (ft)
   );

   srrf_ratio #(
      .DELAY (srrf_pkg::RATIO_DELAY)
   ) u_ratio (
      .clock               (clock),
      .en                  (en),
      .soil_water          (req_soil_water),
      .field_capacity      (req_field_capacity),
      .moisture_half_sat   (req_moisture_half_sat),
      .appearance          (req_appearance),
      .appearance_half_sat (req_appearance_half_sat),
      .fs                  (fs)
   );

   always_comb begin
      vld_in    = {vld_ff[LAT-2:0], req_valid};
      ph_in     = 43'(ft[srrf_pkg::FT_W-1:18]) * 43'(fs);
      pl_in     = 43'(ft[17:0]) * 43'(fs);
      prod_in   = {ph_ff, 18'b0} + 61'(pl_ff);
      rnd       = 63'(prod_ff) + srrf_pkg::ROUND_HALF;
      rate_full = rnd[62:38];
      sat_in    = (rate_full > srrf_pkg::OUT_MAX);
      rate_in   = sat_in ? srrf_pkg::OUT_MAX[srrf_pkg::RATE_W-1:0]
                         : rate_full[srrf_pkg::RATE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         prod_ff <= prod_in;
         rate_ff <= rate_in;
         sat_ff  <= sat_in;
      end
   end

   // output register plus skid; the skid only fills when the output is stalled
   always_comb begin
      tail_vld      = vld_ff[LAT-1];
      out_from_skid = skid_vld_ff && rsp_ready;
      out_load      = !skid_vld_ff && tail_vld && (!out_vld_ff || rsp_ready);
      skid_load     = !skid_vld_ff && tail_vld && out_vld_ff && !rsp_ready;
      out_vld_in    = out_vld_ff;
      skid_vld_in   = skid_vld_ff;
      if (out_from_skid) begin
         skid_vld_in = 1'b0;
      end else if (out_load) begin
         out_vld_in = 1'b1;
      end else if (skid_load) begin
         skid_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_from_skid) begin
         out_rate_ff <= skid_rate_ff;
         out_sat_ff  <= skid_sat_ff;
      end else if (out_load) begin
         out_rate_ff <= rate_ff;
         out_sat_ff  <= sat_ff;
      end
      if (skid_load) begin
         skid_rate_ff <= rate_ff;
         skid_sat_ff  <= sat_ff;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_rate_factor = out_rate_ff;
   assign rsp_saturated   = out_sat_ff;

   a_skid_needs_out : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a result while output register is empty");

   a_skid_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(vld_ff[LAT-1] && out_vld_ff && !rsp_ready))
      else $error("skid filled without a stalled output");

   a_no_clip : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_saturated)
      else $error("rate factor clipped");

endmodule
